>>> rtl/rlog_pkg.sv
// Shared types, constants and codes for the redo log transaction controller.
package rlog_pkg;

    localparam int LOG_ENTRIES   = 30;
    localparam int MAX_OP_BLOCKS = 10;

    localparam int CNT_W  = 5;
    localparam int OPS_W  = 6;
    localparam int NEED_W = 11;

    localparam logic [OPS_W-1:0] OPS_MAX = '1;

    // Request commands.
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_LOG   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_COPY   = 2'd1;
    localparam logic [1:0] KIND_HEADER = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WAIT     = 3'd1;
    localparam logic [2:0] ST_TOO_BIG  = 3'd2;
    localparam logic [2:0] ST_OUTSIDE  = 3'd3;
    localparam logic [2:0] ST_NO_BEGIN = 3'd4;

    // Result selection from the controller to the datapath.
    localparam logic [2:0] RES_REPLY     = 3'd0;
    localparam logic [2:0] RES_COPY      = 3'd1;
    localparam logic [2:0] RES_HDR       = 3'd2;
    localparam logic [2:0] RES_INSTALL   = 3'd3;
    localparam logic [2:0] RES_HDR_EMPTY = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOG_START = 2'd0;
    localparam logic [1:0] REG_LOG_SIZE  = 2'd1;
    localparam logic [1:0] REG_DEVICE_ID = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] block_number;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] source_block;
        logic [31:0] dest_block;
        logic [4:0]  header_count;
        logic        unpin;
        logic        pin_new;
        logic [7:0]  device;
        logic        last;
    } res_item_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] res_sel;
        logic [2:0] status;
        logic       pin;
        logic       idx_clr;
        logic       idx_inc;
        logic       ops_inc;
        logic       ops_dec;
        logic       append;
        logic       cnt_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       begin_ok;
        logic       ops_zero;
        logic       ops_one;
        logic       count_zero;
        logic       log_full;
        logic       idx_at_count;
        logic       idx_at_last;
        logic       hit;
        logic       slot_free;
    } dp_stat_t;

endpackage

>>> rtl/rlog_dp.sv
// Datapath: request latch, logged block table, counters and result register.
module rlog_dp
    import rlog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_item_t   cmd_item,
    input  dp_cmd_t     ctl,
    output dp_stat_t    stat,
    input  logic [31:0] log_start,
    input  logic [10:0] log_size,
    input  logic [7:0]  device_id,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item
);

    logic [31:0]       table_mem [LOG_ENTRIES];
    logic [1:0]        cmd_reg;
    logic [31:0]       blk_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [OPS_W-1:0]  ops_reg;
    logic              res_valid_reg;
    res_item_t         res_reg;
    res_item_t         res_next;

    logic [31:0]       entry_rd;
    logic [31:0]       log_addr;
    logic [NEED_W-1:0] need;

    assign entry_rd = table_mem[idx_reg];
    assign log_addr = log_start + 32'(idx_reg) + 32'd1;
    assign need     = NEED_W'(count_reg)
                    + NEED_W'((7'(ops_reg) + 7'd1) * 7'(MAX_OP_BLOCKS));

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.begin_ok     = (ops_reg != OPS_MAX) && (need <= NEED_W'(LOG_ENTRIES));
        stat.ops_zero     = (ops_reg == '0);
        stat.ops_one      = (ops_reg == OPS_W'(1));
        stat.count_zero   = (count_reg == '0);
        stat.log_full     = (count_reg >= CNT_W'(LOG_ENTRIES))
                         || ((11'(count_reg) + 11'd1) >= log_size);
        stat.idx_at_count = (idx_reg == count_reg);
        stat.idx_at_last  = (idx_reg == (count_reg - CNT_W'(1)));
        stat.hit          = (entry_rd == blk_reg);
        stat.slot_free    = !res_valid_reg || res_ready;
    end

    always_comb
    begin
        res_next = '0;
        res_next.device = device_id;
        case (ctl.res_sel)
            RES_REPLY:
            begin
                res_next.kind    = KIND_STATUS;
                res_next.status  = ctl.status;
                res_next.pin_new = ctl.pin;
                res_next.device  = '0;
                res_next.last    = 1'b1;
            end
            RES_COPY:
            begin
                res_next.kind         = KIND_COPY;
                res_next.source_block = entry_rd;
                res_next.dest_block   = log_addr;
            end
            RES_HDR:
            begin
                res_next.kind         = KIND_HEADER;
                res_next.dest_block   = log_start;
                res_next.header_count = count_reg;
            end
            RES_INSTALL:
            begin
                res_next.kind         = KIND_COPY;
                res_next.source_block = log_addr;
                res_next.dest_block   = entry_rd;
                res_next.unpin        = 1'b1;
            end
            RES_HDR_EMPTY:
            begin
                res_next.kind       = KIND_HEADER;
                res_next.dest_block = log_start;
                res_next.last       = 1'b1;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            ops_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_clr)
                count_reg <= '0;
            else if (ctl.append)
                count_reg <= count_reg + CNT_W'(1);

            if (ctl.idx_clr)
                idx_reg <= '0;
            else if (ctl.idx_inc)
                idx_reg <= idx_reg + CNT_W'(1);

            if (ctl.ops_inc)
                ops_reg <= ops_reg + OPS_W'(1);
            else if (ctl.ops_dec)
                ops_reg <= ops_reg - OPS_W'(1);

            if (ctl.emit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_item.cmd;
            blk_reg <= cmd_item.block_number;
        end
        if (ctl.append)
            table_mem[count_reg] <= blk_reg;
        if (ctl.emit)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // The table never holds more entries than it has rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LOG_ENTRIES))
        else $error("logged block count beyond table depth");

    // A result is only loaded when the result register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!res_valid_reg || res_ready))
        else $error("result overwritten while still waiting");

    // An append always finds a free row.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.append |-> (count_reg < CNT_W'(LOG_ENTRIES)))
        else $error("append into a full table");

endmodule

>>> rtl/rlog_ctrl.sv
// Controller state machine sequencing command handling, search and commit.
module rlog_ctrl
    import rlog_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_COPY    = 3'd3;
    localparam logic [2:0] S_HDR     = 3'd4;
    localparam logic [2:0] S_INSTALL = 3'd5;
    localparam logic [2:0] S_HDR_END = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        cmd_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.slot_free)
                begin
                    ctl.res_sel = RES_REPLY;
                    ctl.emit    = 1'b1;
                    ctl.status  = ST_OK;
                    state_next  = S_IDLE;
                    case (stat.cmd)
                        CMD_BEGIN:
                        begin
                            ctl.ops_inc = stat.begin_ok;
                            ctl.status  = stat.begin_ok ? ST_OK : ST_WAIT;
                        end
                        CMD_END:
                        begin
                            if (stat.ops_zero)
                                ctl.status = ST_NO_BEGIN;
                            else if (stat.ops_one && !stat.count_zero)
                            begin
                                ctl.ops_dec = 1'b1;
                                ctl.emit    = 1'b0;
                                ctl.idx_clr = 1'b1;
                                state_next  = S_COPY;
                            end
                            else
                                ctl.ops_dec = 1'b1;
                        end
                        CMD_LOG:
                        begin
                            if (stat.log_full)
                                ctl.status = ST_TOO_BIG;
                            else if (stat.ops_zero)
                                ctl.status = ST_OUTSIDE;
                            else
                            begin
                                ctl.emit    = 1'b0;
                                ctl.idx_clr = 1'b1;
                                state_next  = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            ctl.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ctl.res_sel = RES_REPLY;
                ctl.status  = ST_OK;
                if (stat.idx_at_count)
                begin
                    if (stat.slot_free)
                    begin
                        ctl.append = 1'b1;
                        ctl.pin    = 1'b1;
                        ctl.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.hit)
                begin
                    if (stat.slot_free)
                    begin
                        ctl.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    ctl.idx_inc = 1'b1;
            end
            S_COPY:
            begin
                ctl.res_sel = RES_COPY;
                if (stat.slot_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.idx_at_last)
                        state_next = S_HDR;
                    else
                        ctl.idx_inc = 1'b1;
                end
            end
            S_HDR:
            begin
                ctl.res_sel = RES_HDR;
                if (stat.slot_free)
                begin
                    ctl.emit    = 1'b1;
                    ctl.idx_clr = 1'b1;
                    state_next  = S_INSTALL;
                end
            end
            S_INSTALL:
            begin
                ctl.res_sel = RES_INSTALL;
                if (stat.slot_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.idx_at_last)
                        state_next = S_HDR_END;
                    else
                        ctl.idx_inc = 1'b1;
                end
            end
            S_HDR_END:
            begin
                ctl.res_sel = RES_HDR_EMPTY;
                if (stat.slot_free)
                begin
                    ctl.emit    = 1'b1;
                    ctl.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/redo_log_transaction_controller.sv
// Top level of the redo log transaction controller: configuration port and wiring.
//
// Requests arrive on the cmd channel (cmd_valid/cmd_ready, payload cmd_item)
// and results leave on the res channel (res_valid/res_ready, payload res_item).
// Every request yields one status reply, except an end that closes the last
// open operation while blocks are logged: that request yields the whole
// group commit (2*n+2 disk operations for n logged blocks) and no reply.
// The final result of each request carries last.
// Begin, end and rejected commands are answered from the execute state through
// the result register. A log command walks the table one entry per cycle.
// A commit emits one disk operation per cycle while the receiver keeps up.
// The table walk and the commit sequencer therefore set the rate: one request
// at a time, with n at most 30.
// A new request is taken as soon as the sequencer is idle, even while the
// previous result still sits in the result register. When the receiver
// stalls, the result is held and the sequencer waits in place.
// Reset clears the open operation count, the table fill count and the
// sequencer, and restores the configuration defaults; the table contents are
// not cleared, as only entries below the fill count are ever read.
// Configuration is written over an APB-style port at byte addresses 0, 4 and 8.
module redo_log_transaction_controller
    import rlog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] log_start_reg;
    logic [10:0] log_size_reg;
    logic [7:0]  device_id_reg;
    logic        cfg_write;

    dp_cmd_t     ctl;
    dp_stat_t    stat;

    // The port never inserts wait states; a write lands in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_start_reg <= 32'd2;
            log_size_reg  <= 11'd30;
            device_id_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LOG_START: log_start_reg <= pwdata;
                REG_LOG_SIZE:  log_size_reg  <= pwdata[10:0];
                REG_DEVICE_ID: device_id_reg <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Reads return the register contents, zero-extended; unused addresses read zero.
    always_comb
    begin
        case (paddr[3:2])
            REG_LOG_START: prdata = log_start_reg;
            REG_LOG_SIZE:  prdata = {21'd0, log_size_reg};
            REG_DEVICE_ID: prdata = {24'd0, device_id_reg};
            default:       prdata = '0;
        endcase
    end

    // The controller decides what happens to each request; the datapath holds
    // the table, the counters and the result register.
    rlog_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    rlog_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .ctl       (ctl),
        .stat      (stat),
        .log_start (log_start_reg),
        .log_size  (log_size_reg),
        .device_id (device_id_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the redo log transaction controller.
module testbench;
    import rlog_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int TAIL_CYCLES     = 80;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 50;

    // The fourth command code has no name in the package; the block treats it
    // as a no-op that still earns an ok reply.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Directed rows either issue a request or write a register.
    localparam logic ROW_REQ = 1'b0;
    localparam logic ROW_CFG = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam logic TYPED     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [1:0]  code;
        logic [31:0] value;
        logic        typed;
        logic [2:0]  status;
    } directed_row_t;

    localparam int NUM_ROWS = 32;

    // The opening sequence. Typed rows carry a reply status that can be read
    // straight off the rules; the rest are left to the predictor.
    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Misuse straight after reset: end without begin, log outside a
        // transaction and the unused command code.
        '{ROW_REQ, CMD_END,       32'h0000_0000, TYPED,     ST_NO_BEGIN},
        '{ROW_REQ, CMD_LOG,       32'h0000_0000, TYPED,     ST_OUTSIDE},
        '{ROW_REQ, CMD_UNKNOWN,   32'hFFFF_FFFF, TYPED,     ST_OK},
        // Three operations fill the worst-case reservation; a fourth waits.
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_BEGIN,     32'hFFFF_FFFF, TYPED,     ST_OK},
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_WAIT},
        // New entries, one repeat that is absorbed, and extreme block numbers.
        '{ROW_REQ, CMD_LOG,       32'h0000_0000, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'hFFFF_FFFF, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h0000_0000, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h8000_0000, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h5555_5555, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_WAIT},
        // Ends with others still open, then the last end runs the commit.
        '{ROW_REQ, CMD_END,       32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_END,       32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_END,       32'h0000_0000, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_END,       32'h0000_0000, TYPED,     ST_NO_BEGIN},
        // A log region just below the top of the block space, so that the
        // log slot numbers wrap round to zero.
        '{ROW_CFG, REG_LOG_START, 32'hFFFF_FFFE, PREDICTED, ST_OK},
        '{ROW_CFG, REG_DEVICE_ID, 32'h0000_00FF, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_LOG,       32'hAAAA_AAAA, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h1234_5678, PREDICTED, ST_OK},
        // Shrinking the log under an open transaction makes it too big.
        '{ROW_CFG, REG_LOG_SIZE,  32'h0000_0002, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h0000_0001, TYPED,     ST_TOO_BIG},
        '{ROW_REQ, CMD_END,       32'h0000_0000, PREDICTED, ST_OK},
        // The smallest log holds a single entry.
        '{ROW_REQ, CMD_BEGIN,     32'h0000_0000, TYPED,     ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h0000_0003, PREDICTED, ST_OK},
        '{ROW_REQ, CMD_LOG,       32'h0000_0004, TYPED,     ST_TOO_BIG},
        '{ROW_REQ, CMD_END,       32'h0000_0000, PREDICTED, ST_OK},
        '{ROW_CFG, REG_LOG_SIZE,  32'h0000_0400, PREDICTED, ST_OK},
        '{ROW_CFG, REG_LOG_START, 32'h0000_0000, PREDICTED, ST_OK},
        '{ROW_CFG, REG_DEVICE_ID, 32'h0000_0000, PREDICTED, ST_OK}
    };

    // Every input has a known value from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd_item  = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // The testbench's own copy of the journal state and the registers, at
    // their reset values.
    logic [31:0] cfg_log_start = 32'd2;
    logic [10:0] cfg_log_size  = 11'd30;
    logic [7:0]  cfg_device    = 8'd1;
    logic [31:0] logged_blk [LOG_ENTRIES];
    int          fill_count = 0;
    int          open_ops   = 0;

    // Disk operations and replies still owed by the block, oldest first.
    res_item_t   awaited_results [$];

    int          mismatches  = 0;
    int          cycle_count = 0;
    int          sent_items  = 0;
    int          stall_left  = 0;
    bit          idling      = 1'b0;

    redo_log_transaction_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // A run that hangs is cut off here. The limit is several times the time
    // that the slowest correct run could take.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("redo_log_transaction_controller verification failed");
            $finish;
        end
    end

    // The receiver stalls in bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 9) == 0)
        begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    function automatic res_item_t status_reply(input logic [2:0] status,
                                               input logic pin);
        res_item_t r;
        r         = '0;
        r.kind    = KIND_STATUS;
        r.status  = status;
        r.pin_new = pin;
        r.last    = 1'b1;
        return r;
    endfunction

    // Group commit: copy every logged block into its log slot, write the
    // header, install each slot back to its home block, then clear the header.
    task automatic predict_commit();
        res_item_t   r;
        logic [31:0] slot;
        for (int i = 0; i < fill_count; i++)
        begin
            r              = '0;
            r.kind         = KIND_COPY;
            r.source_block = logged_blk[i];
            r.dest_block   = cfg_log_start + 32'(i) + 32'd1;
            r.device       = cfg_device;
            awaited_results.push_back(r);
        end
        r              = '0;
        r.kind         = KIND_HEADER;
        r.dest_block   = cfg_log_start;
        r.header_count = 5'(fill_count);
        r.device       = cfg_device;
        awaited_results.push_back(r);
        for (int i = 0; i < fill_count; i++)
        begin
            slot           = cfg_log_start + 32'(i) + 32'd1;
            r              = '0;
            r.kind         = KIND_COPY;
            r.source_block = slot;
            r.dest_block   = logged_blk[i];
            r.unpin        = 1'b1;
            r.device       = cfg_device;
            awaited_results.push_back(r);
        end
        r            = '0;
        r.kind       = KIND_HEADER;
        r.dest_block = cfg_log_start;
        r.device     = cfg_device;
        r.last       = 1'b1;
        awaited_results.push_back(r);
        fill_count = 0;
    endtask

    // Works out what one accepted request must produce and updates the
    // journal state to match.
    task automatic predict_journal(input cmd_item_t req);
        bit hit;
        hit = 1'b0;
        case (req.cmd)
            CMD_BEGIN:
            begin
                // Room is reserved for the worst case of every open operation.
                if (open_ops >= int'(OPS_MAX) ||
                    fill_count + (open_ops + 1) * MAX_OP_BLOCKS > LOG_ENTRIES)
                begin
                    awaited_results.push_back(status_reply(ST_WAIT, 1'b0));
                end
                else
                begin
                    open_ops++;
                    awaited_results.push_back(status_reply(ST_OK, 1'b0));
                end
            end
            CMD_END:
            begin
                if (open_ops == 0)
                begin
                    awaited_results.push_back(status_reply(ST_NO_BEGIN, 1'b0));
                end
                else
                begin
                    open_ops--;
                    if (open_ops == 0 && fill_count > 0)
                        predict_commit();
                    else
                        awaited_results.push_back(status_reply(ST_OK, 1'b0));
                end
            end
            CMD_LOG:
            begin
                // The size check is made before the transaction check.
                if (fill_count >= LOG_ENTRIES || fill_count + 1 >= int'(cfg_log_size))
                begin
                    awaited_results.push_back(status_reply(ST_TOO_BIG, 1'b0));
                end
                else if (open_ops == 0)
                begin
                    awaited_results.push_back(status_reply(ST_OUTSIDE, 1'b0));
                end
                else
                begin
                    for (int i = 0; i < fill_count; i++)
                        if (logged_blk[i] == req.block_number)
                            hit = 1'b1;
                    if (hit)
                    begin
                        awaited_results.push_back(status_reply(ST_OK, 1'b0));
                    end
                    else
                    begin
                        logged_blk[fill_count] = req.block_number;
                        fill_count++;
                        awaited_results.push_back(status_reply(ST_OK, 1'b1));
                    end
                end
            end
            default:
            begin
                awaited_results.push_back(status_reply(ST_OK, 1'b0));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Each result taken by the receiver is held against the oldest one owed.
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t ns: result with none expected, got %h", $time, res_item);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind",         32'(want.kind),         32'(res_item.kind));
                check_field("status",       32'(want.status),       32'(res_item.status));
                check_field("source_block", want.source_block,      res_item.source_block);
                check_field("dest_block",   want.dest_block,        res_item.dest_block);
                check_field("header_count", 32'(want.header_count), 32'(res_item.header_count));
                check_field("unpin",        32'(want.unpin),        32'(res_item.unpin));
                check_field("pin_new",      32'(want.pin_new),      32'(res_item.pin_new));
                check_field("device",       32'(want.device),       32'(res_item.device));
                check_field("last",         32'(want.last),         32'(res_item.last));
            end
        end
    end

    // Offers one request and holds it until it is taken. The caller is always
    // just past a rising edge. On return valid may still be high, so the caller
    // either offers the next request or lowers valid in the same step.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] blk,
                                input logic typed, input logic [2:0] status);
        cmd_item_t req;
        req.cmd          = cmd;
        req.block_number = blk;
        cmd_valid <= 1'b1;
        cmd_item  <= req;
        do
            @(posedge clk);
        while (!cmd_ready);
        predict_journal(req);
        if (typed)
            awaited_results[awaited_results.size() - 1] = status_reply(status, 1'b0);
        sent_items++;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // The sender holds back until every owed result has come. It waits on the
    // clock before it checks, so valid is never driven twice in one step.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // APB write: a setup phase, then an access phase that ends when pready is
    // seen. The local copy of the register changes at that same edge. The bus
    // then returns to idle, so that back-to-back writes keep their setup phase.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (index)
            REG_LOG_START: cfg_log_start = value;
            REG_LOG_SIZE:  cfg_log_size  = value[10:0];
            REG_DEVICE_ID: cfg_device    = value[7:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Repeats of blocks already in the table exercise absorption; the rest
    // are fresh numbers with the occasional extreme.
    function automatic logic [31:0] pick_block();
        if (fill_count > 0 && $urandom_range(0, 2) == 0)
            return logged_blk[$urandom_range(0, fill_count - 1)];
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A well-formed transaction: open one to three operations, log a run of
    // blocks, then close them all. Now and then the run is long enough to
    // fill the table.
    task automatic run_transaction();
        int openers;
        int logs;
        openers = $urandom_range(1, 3);
        logs    = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 34)
                                              : $urandom_range(0, 8);
        repeat (openers) send_request(CMD_BEGIN, $urandom, PREDICTED, ST_OK);
        repeat (logs) send_request(CMD_LOG, pick_block(), PREDICTED, ST_OK);
        repeat (openers) send_request(CMD_END, $urandom, PREDICTED, ST_OK);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling = 1'b1;

        // Directed part. Register writes wait until the block is idle.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
            begin
                drain_results();
                write_register(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].value);
            end
            else
            begin
                send_request(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].value,
                             DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].status);
            end
        end

        // Random part in phases, each with its own register settings. The
        // first phases take the extremes; phases 2, 5 and the last run without idling.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    write_register(REG_LOG_START, 32'h0000_0000);
                    write_register(REG_LOG_SIZE,  32'd1024);
                    write_register(REG_DEVICE_ID, 32'h0000_0000);
                end
                1:
                begin
                    write_register(REG_LOG_START, 32'hFFFF_FFF0);
                    write_register(REG_LOG_SIZE,  32'd32);
                    write_register(REG_DEVICE_ID, 32'h0000_00FF);
                end
                2:
                begin
                    write_register(REG_LOG_START, $urandom);
                    write_register(REG_LOG_SIZE,  32'd2);
                    write_register(REG_DEVICE_ID, $urandom_range(0, 255));
                end
                default:
                begin
                    write_register(REG_LOG_START, $urandom);
                    write_register(REG_LOG_SIZE,  $urandom_range(0, 1) != 0
                                                  ? $urandom_range(2, 40)
                                                  : $urandom_range(2, 1024));
                    write_register(REG_DEVICE_ID, $urandom_range(0, 255));
                end
            endcase
            idling = (phase % 3 != 2) && (phase != NUM_PHASES - 1);
            sent_items = 0;
            while (sent_items < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // Noise and broken sequences: any command in any state.
                    send_request(2'($urandom_range(0, 3)), $urandom, PREDICTED, ST_OK);
                end
                else
                begin
                    run_transaction();
                end
                // Hold the sender back until the block has caught up.
                if ($urandom_range(0, 4) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("redo_log_transaction_controller verification clean");
        else
            $display("redo_log_transaction_controller verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/rlog_pkg.sv
rtl/rlog_dp.sv
rtl/rlog_ctrl.sv
rtl/redo_log_transaction_controller.sv
verif/testbench.sv
